@@ src/sem_pkg.sv @@
// Shared types and constants of the Sobel edge magnitude unit.
// No dependencies.
`timescale 1ns / 1ps

package sem_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Configuration register indexes and widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

    // Stream words
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Largest square that still rounds to 255
    localparam logic [20:0] MAG_CLAMP_SQ = 21'd65280;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQUARE,
        ST_ROOT,
        ST_ROUND,
        ST_EMIT
    } t_state;

endpackage

@@ src/sobel_edge_magnitude_unit.sv @@
// Sobel edge magnitude unit: line stores, 3x3 window, gradient and rounded root.
// Depends on sem_pkg.
`timescale 1ns / 1ps

// Takes RGB words in raster order (red in the low byte) and returns for each
// pixel the rounded gradient magnitude per channel, clamped to 255, with its
// row and column; pixels outside the frame count as zero. One input word is
// handled at a time: the line store read and window update, then for each
// result the gradient, squares, an 8-step bit-serial square root and
// rounding. A word may complete no neighborhood, or up to four results at the
// frame's end, and each result can stall on the output. The line stores are
// synchronous memories read at the incoming column and written back in the
// following cycle. Writing a configuration register restarts the frame at
// row 0, column 0.
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic [sem_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // output words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: out_row[11:0], out_column[22:12], red_edge[30:23],
    //        green_edge[38:31], blue_edge[46:39], zero[47]
    output logic [sem_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast
);
    import sem_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CPW = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RPW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration and frame position
    logic [11:0]    r_cfg_w;
    logic [12:0]    r_cfg_h;
    logic [CPW-1:0] r_col;
    logic [RPW-1:0] r_row;
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;

    // Current word
    logic [CPW-1:0] r_cur_c;
    logic [RPW-1:0] r_cur_r;
    logic [23:0]    r_pix;
    logic [23:0]    r_up_q;
    logic [23:0]    r_mid_q;
    logic [23:0]    r_win [9];

    // Result sequencing
    t_state r_state, n_state;
    logic   r_rsel, r_csel, r_rend, r_cend, r_cstart;

    // Arithmetic
    logic signed [11:0] r_gx [3];
    logic signed [11:0] r_gy [3];
    logic [20:0]        r_sq [3];
    logic [7:0]         r_q  [3];
    logic [2:0]         r_bit;
    logic [7:0]         r_mag [3];

    // Memories
    logic [23:0] upper_mem  [MAX_WIDTH];
    logic [23:0] middle_mem [MAX_WIDTH];

    logic        in_acc;
    logic        out_free;
    logic [CPW-1:0] acc_c;
    logic [RPW-1:0] acc_r;
    logic        restart;
    logic        has_up, has_cur, has_left, has_right;
    logic        last_res;
    logic [RPW-1:0] res_r;
    logic [CPW-1:0] res_c;

    // Effective frame size after clamping
    always_comb begin
        if (r_cfg_w == '0)
            w_eff = WW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(r_cfg_w);
        if (r_cfg_h == '0)
            h_eff = HW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(r_cfg_h);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    // Position of the arriving word, restarting when out of frame
    assign restart = (32'(r_col) >= 32'(w_eff)) || (32'(r_row) >= 32'(h_eff));
    assign acc_c   = restart ? '0 : r_col;
    assign acc_r   = restart ? '0 : r_row;

    // Which results the current word completes
    assign has_up    = (r_cur_r != '0);
    assign has_cur   = (32'(r_cur_r) == 32'(h_eff) - 1);
    assign has_left  = (r_cur_c != '0);
    assign has_right = (32'(r_cur_c) == 32'(w_eff) - 1);
    assign last_res  = (r_rsel == r_rend) && (r_csel == r_cend);
    assign res_r     = r_cur_r - RPW'(!r_rsel);
    assign res_c     = r_cur_c - CPW'(!r_csel);

    // Configuration and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_FRAME_WIDTH;
            r_cfg_h <= RST_FRAME_HEIGHT;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg_wr_en &&
                     (i_cfg_addr == CFG_FRAME_WIDTH || i_cfg_addr == CFG_FRAME_HEIGHT)) begin
            if (i_cfg_addr == CFG_FRAME_WIDTH)
                r_cfg_w <= i_cfg_data[11:0];
            else
                r_cfg_h <= i_cfg_data;
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (32'(acc_c) + 1 >= 32'(w_eff)) begin
                r_col <= '0;
                r_row <= (32'(acc_r) + 1 >= 32'(h_eff)) ? '0 : acc_r + RPW'(1);
            end else begin
                r_col <= acc_c + CPW'(1);
                r_row <= acc_r;
            end
        end
    end

    // Line stores: read at accept, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_up_q  <= upper_mem[acc_c];
            r_mid_q <= middle_mem[acc_c];
        end
        if (r_state == ST_READ) begin
            upper_mem[r_cur_c]  <= r_mid_q;
            middle_mem[r_cur_c] <= r_pix;
        end
    end

    // Word capture and window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++)
                r_win[i] <= '0;
        end else if (r_state == ST_READ) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= r_up_q;
            r_win[5] <= r_mid_q;
            r_win[8] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix   <= s_axis_tdata;
            r_cur_c <= acc_c;
            r_cur_r <= acc_r;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_READ;
            ST_READ: begin
                if ((has_up || has_cur) && (has_left || has_right))
                    n_state = ST_CALC;
                else
                    n_state = ST_IDLE;
            end
            ST_CALC:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_ROOT;
            ST_ROOT:   if (r_bit == '0) n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free)
                    n_state = last_res ? ST_IDLE : ST_CALC;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    // Result selection: row and column offsets within the window
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rsel   <= !has_up;
            r_rend   <= has_cur;
            r_csel   <= !has_left;
            r_cstart <= !has_left;
            r_cend   <= has_right;
        end else if (r_state == ST_EMIT && out_free && !last_res) begin
            if (r_csel == r_cend) begin
                r_csel <= r_cstart;
                r_rsel <= 1'b1;
            end else begin
                r_csel <= 1'b1;
            end
        end
    end

    // Gradient sums over the masked neighborhood
    always_ff @(posedge i_clk) begin
        int gx, gy, wr, wc, kx, ky, v;
        logic ok;
        logic [3:0] widx;
        if (r_state == ST_CALC) begin
            for (int ch = 0; ch < 3; ch++) begin
                gx = 0;
                gy = 0;
                for (int dr = 0; dr < 3; dr++) begin
                    for (int dc = 0; dc < 3; dc++) begin
                        wr = dr + int'(r_rsel);
                        wc = dc + int'(r_csel);
                        ok = (wr <= 2) && (wc <= 2);
                        if (dr == 0 && res_r == '0) ok = 1'b0;
                        if (dr == 2 && 32'(res_r) == 32'(h_eff) - 1) ok = 1'b0;
                        if (dc == 0 && res_c == '0) ok = 1'b0;
                        if (dc == 2 && 32'(res_c) == 32'(w_eff) - 1) ok = 1'b0;
                        kx = (dc - 1) * ((dr == 1) ? 2 : 1);
                        ky = (dr - 1) * ((dc == 1) ? 2 : 1);
                        widx = 4'(wr * 3 + wc);
                        v = 0;
                        if (ok)
                            v = int'(r_win[widx][ch*8 +: 8]);
                        gx = gx + kx * v;
                        gy = gy + ky * v;
                    end
                end
                r_gx[ch] <= 12'(gx);
                r_gy[ch] <= 12'(gy);
            end
        end
    end

    // Squares, bit-serial floor root, rounding and clamp
    always_ff @(posedge i_clk) begin
        logic [7:0]  cand;
        logic [16:0] lim;
        for (int ch = 0; ch < 3; ch++) begin
            if (r_state == ST_SQUARE) begin
                r_sq[ch] <= 21'(r_gx[ch] * r_gx[ch]) + 21'(r_gy[ch] * r_gy[ch]);
                r_q[ch]  <= '0;
            end else if (r_state == ST_ROOT) begin
                cand = r_q[ch] | (8'd1 << r_bit);
                if (21'(cand * cand) <= r_sq[ch])
                    r_q[ch] <= cand;
            end else if (r_state == ST_ROUND) begin
                lim = 17'(r_q[ch] * r_q[ch]) + 17'(r_q[ch]);
                if (r_sq[ch] > MAG_CLAMP_SQ)
                    r_mag[ch] <= 8'd255;
                else if (r_sq[ch] > 21'(lim))
                    r_mag[ch] <= r_q[ch] + 8'd1;
                else
                    r_mag[ch] <= r_q[ch];
            end
        end
        if (r_state == ST_SQUARE)
            r_bit <= 3'd7;
        else if (r_state == ST_ROOT)
            r_bit <= r_bit - 3'd1;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            m_axis_tdata <= {1'b0, r_mag[2], r_mag[1], r_mag[0], 11'(res_c), 12'(res_r)};
            m_axis_tlast <= last_res;
        end
    end

endmodule

@@ tb/sobel_edge_magnitude_unit_test.sv @@
// Self-checking testbench for the Sobel edge magnitude unit: streams RGB frames,
// predicts row, column and per-channel magnitudes in a local model, checks each word.
// Depends on sem_pkg and sobel_edge_magnitude_unit.
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit_test;
    import sem_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int LIMIT_CYCLES = 1500000;
    localparam int QUIET_CYCLES = 60;
    localparam int RANDOM_ITEMS = 280;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

    typedef struct {
        logic [11:0] row;
        logic [10:0] column;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } t_edge;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: out_row[11:0], out_column[22:12], red_edge[30:23],
    //        green_edge[38:31], blue_edge[46:39], zero[47]
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;

    sobel_edge_magnitude_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state
    logic [23:0] upper_line [2048];
    logic [23:0] middle_line [2048];
    logic [23:0] window [9];
    logic [11:0] cur_row;
    logic [10:0] cur_col;
    logic [11:0] cfg_width;
    logic [12:0] cfg_height;

    logic [23:0] pixel_q [$];
    t_edge       edge_expect_q [$];
    int          err_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    logic        in_taken;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > 2048) return 2048;
        return cfg_width;
    endfunction

    function automatic int eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > 4096) return 4096;
        return cfg_height;
    endfunction

    // round(sqrt(s)), clamped to 255
    function automatic logic [7:0] rounded_root(input int s);
        int r;
        if (s > 65280) return 8'd255;
        r = 0;
        while ((r + 1) * (r + 1) <= s) r++;
        if (s > r * r + r) r++;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic t_edge edge_at(input int R, input int C, input int r, input int c,
                                      input int W, input int H);
        t_edge e;
        int gx, gy, nr, nc, wr, wc, v, kx, ky;
        e.row = r[11:0];
        e.column = c[10:0];
        e.last = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nr = r + dr;
                    nc = c + dc;
                    wr = nr - (R - 2);
                    wc = nc - (C - 2);
                    if (nr < 0 || nr >= H || nc < 0 || nc >= W) continue;
                    if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
                    v = (window[wr * 3 + wc] >> (8 * ch)) & 8'hFF;
                    // Sobel taps: x is column difference, y row difference
                    kx = dc * ((dr == 0) ? 2 : 1);
                    ky = dr * ((dc == 0) ? 2 : 1);
                    gx += kx * v;
                    gy += ky * v;
                end
            end
            case (ch)
                0: e.red = rounded_root(gx * gx + gy * gy);
                1: e.green = rounded_root(gx * gx + gy * gy);
                default: e.blue = rounded_root(gx * gx + gy * gy);
            endcase
        end
        return e;
    endfunction

    // Advance the model by one pixel and queue the edges it completes
    task automatic sobel_predict(input logic [23:0] pix);
        int W, H, R, C, nrow, ncol, n;
        int rows [2];
        int cols [2];
        t_edge e;
        W = eff_width();
        H = eff_height();
        R = cur_row;
        C = cur_col;
        if (C >= W || R >= H) begin
            R = 0;
            C = 0;
        end
        for (int i = 0; i < 3; i++) begin
            window[i * 3] = window[i * 3 + 1];
            window[i * 3 + 1] = window[i * 3 + 2];
        end
        window[2] = upper_line[C];
        window[5] = middle_line[C];
        window[8] = pix;
        upper_line[C] = middle_line[C];
        middle_line[C] = pix;
        nrow = 0;
        ncol = 0;
        if (R >= 1) rows[nrow++] = R - 1;
        if (R == H - 1) rows[nrow++] = R;
        if (C >= 1) cols[ncol++] = C - 1;
        if (C == W - 1) cols[ncol++] = C;
        n = nrow * ncol;
        for (int i = 0; i < nrow; i++) begin
            for (int j = 0; j < ncol; j++) begin
                e = edge_at(R, C, rows[i], cols[j], W, H);
                e.last = (i * ncol + j == n - 1);
                edge_expect_q.push_back(e);
            end
        end
        C++;
        if (C >= W) begin
            C = 0;
            R++;
            if (R >= H) R = 0;
        end
        cur_row = R[11:0];
        cur_col = C[10:0];
    endtask

    // Pixel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pixel_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sobel_predict(s_axis_tdata);
            void'(pixel_q.pop_front());
            in_taken = 1'b1;
        end
    end

    // Receiver backpressure, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Edge monitor and run limit
    always @(posedge i_clk) begin
        t_edge e;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (edge_expect_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                e = edge_expect_q.pop_front();
                if (m_axis_tdata[11:0] != e.row)
                    flag_mismatch($sformatf("row %0d exp %0d", m_axis_tdata[11:0], e.row));
                if (m_axis_tdata[22:12] != e.column)
                    flag_mismatch($sformatf("column %0d exp %0d",
                                            m_axis_tdata[22:12], e.column));
                if (m_axis_tdata[30:23] != e.red)
                    flag_mismatch($sformatf("red %0d exp %0d at %0d,%0d",
                                            m_axis_tdata[30:23], e.red, e.row, e.column));
                if (m_axis_tdata[38:31] != e.green)
                    flag_mismatch($sformatf("green %0d exp %0d at %0d,%0d",
                                            m_axis_tdata[38:31], e.green, e.row, e.column));
                if (m_axis_tdata[46:39] != e.blue)
                    flag_mismatch($sformatf("blue %0d exp %0d at %0d,%0d",
                                            m_axis_tdata[46:39], e.blue, e.row, e.column));
                if (m_axis_tdata[47] != 1'b0)
                    flag_mismatch("pad bit set");
                if (m_axis_tlast != e.last)
                    flag_mismatch($sformatf("tlast %0b exp %0b at %0d,%0d",
                                            m_axis_tlast, e.last, e.row, e.column));
            end
        end
    end

    // Wait until the block has drained and settled
    task automatic wait_quiet();
        while (pixel_q.size() > 0 || s_axis_tvalid || edge_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        if (idx == CFG_FRAME_WIDTH) cfg_width = value[11:0];
        else if (idx == CFG_FRAME_HEIGHT) cfg_height = value[12:0];
        if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
            cur_row = '0;
            cur_col = '0;
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Pick the idling mode of a phase from its number
    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // One frame setting followed by a burst of pixels
    task automatic run_frame(input int w, input int h, input int count, input int mode,
                             input int hold);
        wait_quiet();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        set_idling(mode);
        hold_cycles = hold;
        for (int i = 0; i < count; i++)
            pixel_q.push_back({pick_channel(), pick_channel(), pick_channel()});
    endtask

    initial begin
        int sent, w, h, n, phase;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        err_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        cfg_width = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cur_row = '0;
        cur_col = '0;
        for (int i = 0; i < 9; i++) window[i] = '0;
        for (int i = 0; i < 2048; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default frame size: a few pixels of row 0, no edges yet
        for (int i = 0; i < 4; i++) pixel_q.push_back(24'($urandom));

        // Directed: saturating 3x3 checkerboard of 0 and full scale
        wait_quiet();
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 3);
        for (int i = 0; i < 9; i++) pixel_q.push_back((i % 2) ? 24'hFFFFFF : 24'h000000);
        // single-pixel frames, zero registers acting as one, then 1x4 and 2x1 frames
        run_frame(0, 0, 3, 0, 0);
        run_frame(1, 1, 3, 0, 0);
        run_frame(1, 4, 4, 1, 0);
        run_frame(2, 1, 2, 2, 0);
        // ignored register index keeps the frame position
        run_frame(3, 2, 2, 0, 0);
        wait_quiet();
        write_reg(CFG_UNUSED, 5);
        for (int i = 0; i < 4; i++) pixel_q.push_back({pick_channel(), pick_channel(),
                                                        pick_channel()});
        // oversize registers clamp; a short start of the widest frame
        run_frame(4095, 8191, 3, 0, 0);
        run_frame(4095, 2, 5, 3, 0);

        // Random frames, small sizes
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(3) == 0) n += $urandom_range(1, w * h);
            run_frame(w, h, n, phase, (phase == 3) ? 400 : 0);
            sent += n;
            phase++;
            // sender waits for every edge before the next burst of the same frame
            if (phase % 5 == 0) begin
                wait_quiet();
                for (int i = 0; i < w * h; i++)
                    pixel_q.push_back({pick_channel(), pick_channel(), pick_channel()});
                sent += w * h;
            end
        end

        wait_quiet();
        if (edge_expect_q.size() > 0)
            flag_mismatch($sformatf("%0d edges never came", edge_expect_q.size()));
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
